// ===== rtl/core/ordered_list_insert_delete_defines.svh =====
// assertion macros for the ordered list block
// no dependencies; the bodies vanish when SYNTHESIS is defined
`ifndef ORDERED_LIST_INSERT_DELETE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_DEFINES_SVH
`ifndef SYNTHESIS
`define OLID_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("olid assertion failed");
`define OLID_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("olid assertion failed");
`else
`define OLID_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define OLID_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/core/olid_pkg.sv =====
// types and codes shared by the ordered list block
// no dependencies
`default_nettype none
package olid_pkg;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned COUNT_W  = 5;

	typedef logic [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		CMD_INS_FRONT = 2'd0,
		CMD_INS_END   = 2'd1,
		CMD_DELETE    = 2'd2,
		CMD_LIST      = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 3'd0,
		STS_NOT_FOUND = 3'd1,
		STS_FULL      = 3'd2,
		STS_EMPTY     = 3'd3,
		STS_ELEMENT   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD       = 3'd0,
		CELL_PUSH_FRONT = 3'd1,
		CELL_APPEND     = 3'd2,
		CELL_DELETE     = 3'd3,
		CELL_ROTATE     = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		data_t    data;
	} cell_ctrl_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_LIST = 1'b1
	} fsm_t;
endpackage
`default_nettype wire

// ===== rtl/core/olid_req_if.sv =====
// request channel of the ordered list block
// depends on olid_pkg
`default_nettype none
interface olid_req_if;
	logic                valid;
	logic                ready;
	logic [1:0]          command;
	olid_pkg::data_t     data_value;

	modport source (output valid, output command, output data_value, input ready);
	modport sink (input valid, input command, input data_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/olid_rsp_if.sv =====
// result channel of the ordered list block
// depends on olid_pkg
`default_nettype none
interface olid_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [olid_pkg::STATUS_W-1:0]     status;
	olid_pkg::data_t                   element_value;
	logic [olid_pkg::COUNT_W-1:0]      entry_count;
	logic                              last_result;

	modport source (output valid, output status, output element_value, output entry_count,
		output last_result, input ready);
	modport sink (input valid, input status, input element_value, input entry_count,
		input last_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/olid_cell.sv =====
// one cell of the list chain: holds one entry and its occupied bit
// depends on olid_pkg
`default_nettype none
module olid_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire olid_pkg::cell_ctrl_t ctrl,
	input  wire olid_pkg::data_t      key,
	input  wire olid_pkg::data_t      left_value,
	input  wire logic                 left_valid,
	input  wire olid_pkg::data_t      right_value,
	input  wire logic                 right_valid,
	input  wire olid_pkg::data_t      head_value,
	input  wire logic                 hit_in,
	output logic                      hit_out,
	output olid_pkg::data_t           value,
	output logic                      valid
);
	olid_pkg::data_t val_q;
	olid_pkg::data_t val_d;
	logic            valid_q;
	logic            valid_d;
	logic            match;

	// compare against the request value directly so the hit chain does not loop through ctrl
	assign match   = valid_q && (val_q == key);
	// first match anywhere to the left already claims the delete
	assign hit_out = hit_in || match;
	assign value   = val_q;
	assign valid   = valid_q;

	always_comb begin
		val_d   = val_q;
		valid_d = valid_q;
		unique case (ctrl.op)
			olid_pkg::CELL_HOLD: begin
			end
			olid_pkg::CELL_PUSH_FRONT: begin
				val_d   = left_value;
				valid_d = left_valid;
			end
			olid_pkg::CELL_APPEND: begin
				// first free cell after an occupied one (or cell 0, whose left side counts as occupied) takes the value
				if (!valid_q && left_valid) begin
					val_d   = ctrl.data;
					valid_d = 1'b1;
				end
			end
			olid_pkg::CELL_DELETE: begin
				if (hit_out) begin
					val_d   = right_value;
					valid_d = right_valid;
				end
			end
			olid_pkg::CELL_ROTATE: begin
				// last occupied cell wraps round to the head
				if (valid_q) begin
					val_d = right_valid ? right_value : head_value;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end
endmodule
`default_nettype wire

// ===== rtl/core/ordered_list_insert_delete.sv =====
// ordered list top level: chain of olid_cell, list sequencer and result register
// depends on olid_pkg, olid_req_if, olid_rsp_if, olid_cell, ordered_list_insert_delete_defines.svh
//
// channel  dir  fields
// req      in   command, data_value
// rsp      out  status, element_value, entry_count, last_result
//
// on insert and delete the chain shifts, inserts and compares in all cells in parallel
// list all starts the sequencer, then emits one entry a cycle while the result register is free,
// as the chain rotates by one position per entry, ending back in its original order
// reset clears the occupied bits and the count; entry values are not reset
// a stalled result holds in the output register; no new request is taken while it waits
// unless it is being taken in the same cycle
`default_nettype none
`include "ordered_list_insert_delete_defines.svh"
module ordered_list_insert_delete #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	olid_req_if.sink  req,
	olid_rsp_if.source rsp
);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	olid_pkg::cell_ctrl_t ctrl;
	olid_pkg::data_t      cell_value [CAPACITY];
	logic [CAPACITY-1:0]  cell_valid;
	logic [CAPACITY-1:0]  cell_hit;

	olid_pkg::fsm_t state_q;
	olid_pkg::fsm_t state_d;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  count_d;
	logic [CW-1:0]  rem_q;

	logic                          out_valid_q;
	logic [olid_pkg::STATUS_W-1:0] out_status_q;
	olid_pkg::data_t               out_value_q;
	logic [olid_pkg::COUNT_W-1:0]  out_count_q;
	logic                          out_last_q;

	logic             out_free;
	logic             accept;
	logic             full;
	logic             found;
	logic             ld;
	olid_pkg::status_t ld_status;
	olid_pkg::data_t  ld_value;
	logic             ld_last;
	logic             start_list;
	logic             emit;
	logic [31:0]      count_ext;
	olid_pkg::cmd_t   cmd;

	assign cmd      = olid_pkg::cmd_t'(req.command);
	assign out_free = !out_valid_q || rsp.ready;
	assign accept   = req.valid && out_free && (state_q == olid_pkg::FSM_IDLE);
	assign full     = (count_q == CW'(CAPACITY));
	assign found    = cell_hit[CAPACITY-1];
	assign emit     = (state_q == olid_pkg::FSM_LIST) && out_free;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		olid_pkg::data_t left_value;
		logic            left_valid;
		olid_pkg::data_t right_value;
		logic            right_valid;
		logic            hit_in;

		if (i == 0) begin : g_head
			assign left_value = req.data_value;
			assign left_valid = 1'b1;
			assign hit_in     = 1'b0;
		end else begin : g_body
			assign left_value = cell_value[i-1];
			assign left_valid = cell_valid[i-1];
			assign hit_in     = cell_hit[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_value = '0;
			assign right_valid = 1'b0;
		end else begin : g_mid
			assign right_value = cell_value[i+1];
			assign right_valid = cell_valid[i+1];
		end

		olid_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.key         (req.data_value),
			.left_value  (left_value),
			.left_valid  (left_valid),
			.right_value (right_value),
			.right_valid (right_valid),
			.head_value  (cell_value[0]),
			.hit_in      (hit_in),
			.hit_out     (cell_hit[i]),
			.value       (cell_value[i]),
			.valid       (cell_valid[i])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			olid_pkg::FSM_IDLE: begin
				if (start_list) begin
					state_d = olid_pkg::FSM_LIST;
				end
			end
			olid_pkg::FSM_LIST: begin
				if (emit && rem_q == CW'(1)) begin
					state_d = olid_pkg::FSM_IDLE;
				end
			end
			default: state_d = olid_pkg::FSM_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready  = 1'b0;
		ctrl.op    = olid_pkg::CELL_HOLD;
		ctrl.data  = req.data_value;
		ld         = 1'b0;
		ld_status  = olid_pkg::STS_OK;
		ld_value   = '0;
		ld_last    = 1'b1;
		start_list = 1'b0;
		count_d    = count_q;
		unique case (state_q)
			olid_pkg::FSM_IDLE: begin
				req.ready = out_free;
				if (accept) begin
					unique case (cmd)
						olid_pkg::CMD_INS_FRONT, olid_pkg::CMD_INS_END: begin
							ld = 1'b1;
							if (full) begin
								ld_status = olid_pkg::STS_FULL;
							end else begin
								ctrl.op = (cmd == olid_pkg::CMD_INS_FRONT) ?
									olid_pkg::CELL_PUSH_FRONT : olid_pkg::CELL_APPEND;
								count_d = count_q + CW'(1);
							end
						end
						olid_pkg::CMD_DELETE: begin
							ld = 1'b1;
							if (found) begin
								ctrl.op = olid_pkg::CELL_DELETE;
								count_d = count_q - CW'(1);
							end else begin
								ld_status = olid_pkg::STS_NOT_FOUND;
							end
						end
						olid_pkg::CMD_LIST: begin
							if (count_q == '0) begin
								ld        = 1'b1;
								ld_status = olid_pkg::STS_EMPTY;
							end else begin
								start_list = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			olid_pkg::FSM_LIST: begin
				if (emit) begin
					ctrl.op   = olid_pkg::CELL_ROTATE;
					ld        = 1'b1;
					ld_status = olid_pkg::STS_ELEMENT;
					ld_value  = cell_value[0];
					ld_last   = (rem_q == CW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	assign count_ext = 32'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= olid_pkg::FSM_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (start_list) begin
				rem_q <= count_q;
			end else if (emit) begin
				rem_q <= rem_q - CW'(1);
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_status_q <= ld_status;
			out_value_q  <= ld_value;
			out_count_q  <= count_ext[olid_pkg::COUNT_W-1:0];
			out_last_q   <= ld_last;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.element_value = out_value_q;
	assign rsp.entry_count   = out_count_q;
	assign rsp.last_result   = out_last_q;

	`OLID_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`OLID_ASSERT_IMP(a_valid_matches_count, clk, arst_n, 1'b1,
		$countones(cell_valid) == 32'(count_q))
	`OLID_ASSERT_NXT(a_insert_grows, clk, arst_n,
		accept && !full && (cmd == olid_pkg::CMD_INS_FRONT || cmd == olid_pkg::CMD_INS_END),
		count_q == $past(count_q) + CW'(1))
	`OLID_ASSERT_NXT(a_list_ends, clk, arst_n, emit && rem_q == CW'(1),
		state_q == olid_pkg::FSM_IDLE && rsp.valid && rsp.last_result)
endmodule
`default_nettype wire
